FILE: hw/rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, token codes and character classes for the source tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    // Input item: one source byte or the end marker.
    typedef struct packed {
        logic [7:0] character;
        logic       end_of_text;
    } t_in_item;

    // Result item: one token event.
    typedef struct packed {
        logic [4:0] token_kind;
        logic       appends_char;
        logic [7:0] token_char;
        logic       last_of_run;
    } t_out_item;

    // Token kinds
    localparam logic [4:0] K_LESS          = 5'd0;
    localparam logic [4:0] K_GREATER       = 5'd1;
    localparam logic [4:0] K_LPAR          = 5'd2;
    localparam logic [4:0] K_LSQB          = 5'd3;
    localparam logic [4:0] K_LBRACE        = 5'd4;
    localparam logic [4:0] K_RPAR          = 5'd5;
    localparam logic [4:0] K_RSQB          = 5'd6;
    localparam logic [4:0] K_RBRACE        = 5'd7;
    localparam logic [4:0] K_EQUAL         = 5'd8;
    localparam logic [4:0] K_PLUS          = 5'd9;
    localparam logic [4:0] K_MINUS         = 5'd10;
    localparam logic [4:0] K_STAR          = 5'd11;
    localparam logic [4:0] K_SLASH         = 5'd12;
    localparam logic [4:0] K_BSLASH        = 5'd13;
    localparam logic [4:0] K_COLON         = 5'd14;
    localparam logic [4:0] K_COMMA         = 5'd16;
    localparam logic [4:0] K_DOT           = 5'd17;
    localparam logic [4:0] K_TILDE         = 5'd18;
    localparam logic [4:0] K_AMPER         = 5'd19;
    localparam logic [4:0] K_VBAR          = 5'd20;
    localparam logic [4:0] K_CARET         = 5'd21;
    localparam logic [4:0] K_STRING        = 5'd22;
    localparam logic [4:0] K_NAME          = 5'd23;
    localparam logic [4:0] K_NUMBER        = 5'd24;
    localparam logic [4:0] K_EQ_EQUAL      = 5'd25;
    localparam logic [4:0] K_NOT_EQUAL     = 5'd26;
    localparam logic [4:0] K_LESS_EQUAL    = 5'd27;
    localparam logic [4:0] K_GREATER_EQUAL = 5'd28;
    localparam logic [4:0] K_NEW_LINE      = 5'd29;
    localparam logic [4:0] K_FILE_END      = 5'd30;
    localparam logic [4:0] K_NONE          = 5'd31;

    // Copy modes
    localparam logic [1:0] CM_NONE   = 2'd0;
    localparam logic [1:0] CM_NUMBER = 2'd1;
    localparam logic [1:0] CM_STRING = 2'd2;
    localparam logic [1:0] CM_NAME   = 2'd3;

    // Pending operator codes
    localparam logic [2:0] PEND_NONE    = 3'd0;
    localparam logic [2:0] PEND_LESS    = 3'd1;
    localparam logic [2:0] PEND_GREATER = 3'd2;
    localparam logic [2:0] PEND_EQUAL   = 3'd3;
    localparam logic [2:0] PEND_BANG    = 3'd4;

    // Character codes
    localparam logic [7:0] CH_SEMIC = 8'h3B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_LESS  = 8'h3C;
    localparam logic [7:0] CH_GREAT = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOT) || (c == CH_SQUOT);
    endfunction

    // Kind of a plain single-character token, K_NONE if the byte has none.
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            8'h28:   k = K_LPAR;
            8'h5B:   k = K_LSQB;
            8'h7B:   k = K_LBRACE;
            8'h29:   k = K_RPAR;
            8'h5D:   k = K_RSQB;
            8'h7D:   k = K_RBRACE;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h5C:   k = K_BSLASH;
            8'h3A:   k = K_COLON;
            8'h2C:   k = K_COMMA;
            8'h2E:   k = K_DOT;
            8'h7E:   k = K_TILDE;
            8'h26:   k = K_AMPER;
            8'h7C:   k = K_VBAR;
            8'h5E:   k = K_CARET;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/source_char_tokenizer.sv
// ----------------------------------------------------------------------------
// source_char_tokenizer
// Byte-stream lexer: turns source bytes into token start and append items.
// ----------------------------------------------------------------------------
// Input items are registered, then decoded into the result queue that drives the output port.
// Throughput: one input item per cycle while the result queue has room; an item
// that yields two result items (pending operator flushed ahead of another token)
// needs both entries of the two-entry result queue, drained through one output port.
// Reset (i_rst_n low, synchronous): empty input register and result queue,
// no copy mode, no pending operator.
module source_char_tokenizer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    input  sct_pkg::t_in_item    i_in_item,
    output logic                 o_in_stall,
    // output channel
    output logic                 o_out_valid,
    output sct_pkg::t_out_item   o_out_item,
    input  logic                 i_out_stall
);
    import sct_pkg::*;

    // Input register: holds one item until the result queue has room for it.
    logic       r_in_valid;
    t_in_item   r_in;

    // Lexer state
    logic [1:0] r_copy_mode, n_copy_mode;
    logic [2:0] r_pending,   n_pending;

    // Result queue: entry 0 is the head shown on the output port.
    t_out_item  r_q [2];
    t_out_item  n_q [2];
    logic [1:0] r_cnt, n_cnt;

    // Decode of the registered item
    t_out_item  flush_res, main_res, res0, res1;
    logic       flush_vld, main_vld;
    logic [1:0] n_res;
    logic [1:0] cnt_after_pop;
    logic       pop, proc;
    logic [7:0] c;

    assign c           = r_in.character;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_q[0];
    assign pop         = o_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // Token decode: at most a flushed operator followed by one main token.
    // ------------------------------------------------------------------
    always_comb begin
        flush_vld   = 1'b0;
        main_vld    = 1'b0;
        flush_res   = '0;
        main_res    = '0;
        n_copy_mode = r_copy_mode;
        n_pending   = r_pending;

        // A pending '<', '>' or '=' that finds no partner becomes its own token;
        // a lone '!' yields nothing.
        unique case (r_pending)
            PEND_LESS: begin
                flush_vld = 1'b1;
                flush_res.token_kind = K_LESS;
            end
            PEND_GREATER: begin
                flush_vld = 1'b1;
                flush_res.token_kind = K_GREATER;
            end
            PEND_EQUAL: begin
                flush_vld = 1'b1;
                flush_res.token_kind = K_EQUAL;
            end
            default: flush_vld = 1'b0;
        endcase

        if (r_in.end_of_text) begin
            // End marker: flush, then file end; back to a clean state.
            main_vld            = 1'b1;
            main_res.token_kind = K_FILE_END;
            n_copy_mode         = CM_NONE;
            n_pending           = PEND_NONE;
        end else if (c == CH_SEMIC) begin
            // Row end also drops out of any string.
            main_vld            = 1'b1;
            main_res.token_kind = K_NEW_LINE;
            n_copy_mode         = CM_NONE;
            n_pending           = PEND_NONE;
        end else if ((r_pending != PEND_NONE) && (c == CH_EQUAL)) begin
            // Operator pair: the '=' is consumed, nothing is flushed.
            flush_vld = 1'b0;
            main_vld  = 1'b1;
            n_pending = PEND_NONE;
            unique case (r_pending)
                PEND_LESS:    main_res.token_kind = K_LESS_EQUAL;
                PEND_GREATER: main_res.token_kind = K_GREATER_EQUAL;
                PEND_EQUAL:   main_res.token_kind = K_EQ_EQUAL;
                PEND_BANG:    main_res.token_kind = K_NOT_EQUAL;
                default:      main_res.token_kind = K_LESS;
            endcase
        end else begin
            n_pending = PEND_NONE;
            if (r_copy_mode == CM_STRING) begin
                // Closing quote ends the string; anything else is appended.
                if (is_quote(c)) begin
                    n_copy_mode = CM_NONE;
                end else begin
                    main_vld              = 1'b1;
                    main_res.token_kind   = K_STRING;
                    main_res.appends_char = 1'b1;
                    main_res.token_char   = c;
                end
            end else if ((r_copy_mode == CM_NUMBER) && (is_digit(c) || (c == CH_DOT))) begin
                main_vld              = 1'b1;
                main_res.token_kind   = K_NUMBER;
                main_res.appends_char = 1'b1;
                main_res.token_char   = c;
            end else if ((r_copy_mode == CM_NAME)
                         && (is_alpha(c) || is_digit(c) || (c == CH_UNDER))) begin
                main_vld              = 1'b1;
                main_res.token_kind   = K_NAME;
                main_res.appends_char = 1'b1;
                main_res.token_char   = c;
            end else begin
                // Start of a new token; any name or number ends here.
                n_copy_mode = CM_NONE;
                priority if (c == CH_LESS) begin
                    n_pending = PEND_LESS;
                end else if (c == CH_GREAT) begin
                    n_pending = PEND_GREATER;
                end else if (c == CH_EQUAL) begin
                    n_pending = PEND_EQUAL;
                end else if (c == CH_BANG) begin
                    n_pending = PEND_BANG;
                end else if (is_quote(c)) begin
                    main_vld            = 1'b1;
                    main_res.token_kind = K_STRING;
                    n_copy_mode         = CM_STRING;
                end else if (is_digit(c)) begin
                    main_vld            = 1'b1;
                    main_res.token_kind = K_NUMBER;
                    main_res.token_char = c;
                    n_copy_mode         = CM_NUMBER;
                end else if (is_alpha(c) || (c == CH_UNDER)) begin
                    main_vld            = 1'b1;
                    main_res.token_kind = K_NAME;
                    main_res.token_char = c;
                    n_copy_mode         = CM_NAME;
                end else begin
                    main_res.token_kind = single_kind(c);
                    main_vld            = (main_res.token_kind != K_NONE);
                end
            end
        end
    end

    // Order the results and mark the last one of the item.
    always_comb begin
        res0 = flush_vld ? flush_res : main_res;
        res1 = main_res;
        n_res = {1'b0, flush_vld} + {1'b0, main_vld};
        if (flush_vld && main_vld) begin
            res1.last_of_run = 1'b1;
        end else begin
            res0.last_of_run = 1'b1;
        end
    end

    // Process the held item once the queue, after this cycle's pop, has room.
    assign cnt_after_pop = r_cnt - {1'b0, pop};
    assign proc          = r_in_valid && (n_res <= (2'd2 - cnt_after_pop));
    assign o_in_stall    = r_in_valid && !proc;

    // Queue update: shift out the head on pop, then append new results.
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = cnt_after_pop;
        end
        if (proc) begin
            unique case (n_res)
                2'd1: n_q[n_cnt[0]] = res0;
                2'd2: begin
                    n_q[0] = res0;
                    n_q[1] = res1;
                end
                default: n_q = n_q;
            endcase
            n_cnt = n_cnt + n_res;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cnt       <= 2'd0;
            r_copy_mode <= CM_NONE;
            r_pending   <= PEND_NONE;
        end else begin
            if (proc || !r_in_valid) begin
                r_in_valid <= i_in_valid;
            end
            r_cnt <= n_cnt;
            if (proc) begin
                r_copy_mode <= n_copy_mode;
                r_pending   <= n_pending;
            end
        end
    end

    // Payload registers: hold while stalled, advance otherwise.
    always_ff @(posedge i_clk) begin
        if (proc || !r_in_valid) begin
            r_in <= i_in_item;
        end
        r_q <= n_q;
    end

endmodule
